// ----- rtl/tap_hold_key_remapper_top_macros.svh -----
// ----------------------------------------------------------------------------
// tap_hold_key_remapper_top_macros
// assertion macros for the tap/hold key remapper
// ----------------------------------------------------------------------------
// the first form checks a property, the second checks that an expression never holds
`ifndef TAP_HOLD_KEY_REMAPPER_TOP_MACROS_SVH
`define TAP_HOLD_KEY_REMAPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define THKR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("thkr property violated");
`define THKR_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("thkr forbidden condition seen");
`else
`define THKR_ASSERT(lbl, clk, rst, prop)
`define THKR_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/thkr_pkg.sv -----
// ----------------------------------------------------------------------------
// thkr_pkg
// types, codes and helpers shared by the tap/hold key remapper
// ----------------------------------------------------------------------------
package thkr_pkg;

  // event types and codes
  localparam logic [4:0]  EV_SYNC   = 5'd0;
  localparam logic [4:0]  EV_KEY    = 5'd1;
  localparam logic [4:0]  EV_MISC   = 5'd4;
  localparam logic [15:0] MISC_SCAN = 16'd4;

  // key values
  localparam logic signed [31:0] KEY_RELEASE = 32'sd0;
  localparam logic signed [31:0] KEY_PRESS   = 32'sd1;
  localparam logic signed [31:0] KEY_REPEAT  = 32'sd2;

  // register indexes
  localparam logic [1:0] CFG_TRIGGER = 2'd0;
  localparam logic [1:0] CFG_TAP     = 2'd1;
  localparam logic [1:0] CFG_HOLD    = 2'd2;

  // register reset values
  localparam logic [9:0] TRIGGER_RST = 10'd58;
  localparam logic [9:0] TAP_RST     = 10'd1;
  localparam logic [9:0] HOLD_RST    = 10'd29;

  // slots in one output burst
  localparam int BURST_LEN = 3;

  typedef struct packed {
    logic [4:0]         ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } item_t;

  typedef struct packed {
    logic [4:0]         out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } event_t;

  typedef struct packed {
    logic [9:0] trigger_key;
    logic [9:0] tap_key;
    logic [9:0] hold_key;
  } cfg_t;

  typedef struct packed {
    logic held;
    logic hold_used;
  } state_t;

  typedef struct packed {
    event_t [BURST_LEN-1:0] ev;
    logic   [1:0]           cnt;
  } burst_t;

  typedef struct packed {
    burst_t burst;
    state_t st_next;
  } dec_t;

  // build one output event
  function automatic event_t mk_ev(logic [4:0] t, logic [15:0] c,
                                   logic signed [31:0] v, logic l);
    event_t e;
    e.out_type  = t;
    e.out_code  = c;
    e.out_value = v;
    e.last      = l;
    return e;
  endfunction

endpackage

// ----- rtl/thkr_if.sv -----
// ----------------------------------------------------------------------------
// thkr_if
// request channels of the remapper: input events, output events, config writes
// ----------------------------------------------------------------------------
interface thkr_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         ev_type;
  logic [15:0]        ev_code;
  logic signed [31:0] ev_value;

  modport source (output valid, ev_type, ev_code, ev_value, input ready);
  modport sink   (input valid, ev_type, ev_code, ev_value, output ready);
endinterface

interface thkr_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         out_type;
  logic [15:0]        out_code;
  logic signed [31:0] out_value;
  logic               last;

  modport source (output valid, out_type, out_code, out_value, last, input ready);
  modport sink   (input valid, out_type, out_code, out_value, last, output ready);
endinterface

interface thkr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/thkr_cfg.sv -----
// ----------------------------------------------------------------------------
// thkr_cfg
// configuration registers: trigger, tap and hold key codes
// ----------------------------------------------------------------------------
module thkr_cfg (
  input  logic          clk,
  input  logic          rst,
  thkr_cfg_if.sink      cfg,
  output thkr_pkg::cfg_t regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.trigger_key <= thkr_pkg::TRIGGER_RST;
      regs.tap_key     <= thkr_pkg::TAP_RST;
      regs.hold_key    <= thkr_pkg::HOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        thkr_pkg::CFG_TRIGGER: regs.trigger_key <= cfg.data;
        thkr_pkg::CFG_TAP:     regs.tap_key     <= cfg.data;
        thkr_pkg::CFG_HOLD:    regs.hold_key    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/thkr_decode.sv -----
// ----------------------------------------------------------------------------
// thkr_decode
// turns one input event and the hold state into a burst of up to three events
// ----------------------------------------------------------------------------
module thkr_decode (
  input  thkr_pkg::item_t  item,
  input  thkr_pkg::cfg_t   regs,
  input  thkr_pkg::state_t st,
  output thkr_pkg::dec_t   dec
);

  logic               ours;
  logic               is_scan;
  logic               v_rel;
  logic               v_prs;
  logic               v_rep;
  logic [15:0]        tap_code;
  logic [15:0]        hold_code;
  thkr_pkg::event_t   pass_ev;

  // key matches and value classes
  assign ours      = (item.ev_code == {6'd0, regs.trigger_key}) ||
                     (item.ev_code == {6'd0, regs.hold_key});
  assign is_scan   = (item.ev_type == thkr_pkg::EV_MISC) &&
                     (item.ev_code == thkr_pkg::MISC_SCAN);
  assign v_rel     = (item.ev_value == thkr_pkg::KEY_RELEASE);
  assign v_prs     = (item.ev_value == thkr_pkg::KEY_PRESS);
  assign v_rep     = (item.ev_value == thkr_pkg::KEY_REPEAT);
  assign tap_code  = {6'd0, regs.tap_key};
  assign hold_code = {6'd0, regs.hold_key};
  assign pass_ev   = thkr_pkg::mk_ev(item.ev_type, item.ev_code, item.ev_value, 1'b1);

  // burst selection, first matching rule wins
  always_comb begin
    dec.st_next   = st;
    dec.burst.cnt = 2'd1;
    dec.burst.ev  = '0;
    dec.burst.ev[0] = pass_ev;
    priority if (is_scan) begin
      dec.burst.cnt = 2'd0;
    end else if (item.ev_type != thkr_pkg::EV_KEY) begin
      dec.burst.cnt = 2'd1;
    end else if (st.held && ours && (v_prs || v_rep)) begin
      dec.burst.cnt = 2'd0;
    end else if (st.held && ours && v_rel && st.hold_used) begin
      dec.st_next   = '0;
      dec.burst.ev[0] = thkr_pkg::mk_ev(thkr_pkg::EV_KEY, hold_code,
                                        thkr_pkg::KEY_RELEASE, 1'b1);
    end else if (st.held && ours && v_rel) begin
      // tap burst: tap down, sync, tap up
      dec.st_next   = '0;
      dec.burst.cnt = 2'd3;
      dec.burst.ev[0] = thkr_pkg::mk_ev(thkr_pkg::EV_KEY, tap_code,
                                        thkr_pkg::KEY_PRESS, 1'b0);
      dec.burst.ev[1] = thkr_pkg::mk_ev(thkr_pkg::EV_SYNC, 16'd0,
                                        thkr_pkg::KEY_RELEASE, 1'b0);
      dec.burst.ev[2] = thkr_pkg::mk_ev(thkr_pkg::EV_KEY, tap_code,
                                        thkr_pkg::KEY_RELEASE, 1'b1);
    end else if (st.held && !st.hold_used && !v_rel) begin
      // other key while held: hold down, sync, then the key itself
      dec.st_next.hold_used = 1'b1;
      dec.burst.cnt = 2'd3;
      dec.burst.ev[0] = thkr_pkg::mk_ev(thkr_pkg::EV_KEY, hold_code,
                                        thkr_pkg::KEY_PRESS, 1'b0);
      dec.burst.ev[1] = thkr_pkg::mk_ev(thkr_pkg::EV_SYNC, 16'd0,
                                        thkr_pkg::KEY_RELEASE, 1'b0);
      dec.burst.ev[2] = pass_ev;
    end else if (!st.held && ours && v_prs) begin
      dec.st_next.held = 1'b1;
      dec.burst.cnt = 2'd0;
    end else begin
      dec.burst.cnt = 2'd1;
    end
  end

endmodule

// ----- rtl/thkr_burst.sv -----
// ----------------------------------------------------------------------------
// thkr_burst
// output register stage: holds one burst and shifts it out one event a request
// ----------------------------------------------------------------------------
`include "tap_hold_key_remapper_top_macros.svh"

module thkr_burst (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  thkr_pkg::burst_t burst,
  output logic             free,
  thkr_out_if.source       ev_out
);

  thkr_pkg::event_t [thkr_pkg::BURST_LEN-1:0] slot;
  logic [1:0] rem;
  logic [1:0] rem_next;
  logic       pop;

  assign pop  = ev_out.valid && ev_out.ready;
  assign free = (rem == 2'd0) || ((rem == 2'd1) && ev_out.ready);

  // remaining count
  always_comb begin
    priority if (load) rem_next = burst.cnt;
    else if (pop)      rem_next = rem - 2'd1;
    else               rem_next = rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else begin
      rem <= rem_next;
    end
  end

  // payload slots, head is always slot 0
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= burst.ev;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign ev_out.valid     = (rem != 2'd0);
  assign ev_out.out_type  = slot[0].out_type;
  assign ev_out.out_code  = slot[0].out_code;
  assign ev_out.out_value = slot[0].out_value;
  assign ev_out.last      = slot[0].last;

  // last flag marks exactly the final pending event
  `THKR_ASSERT(a_last_on_final, clk, rst, ev_out.valid |-> (ev_out.last == (rem == 2'd1)))
  // a burst never loads over events still pending
  `THKR_NEVER(a_no_overwrite, clk, rst, load && (rem > 2'd1))
  // a loaded non-empty burst is offered next cycle
  `THKR_ASSERT(a_load_shows, clk, rst, (load && (burst.cnt != 2'd0)) |=> ev_out.valid)

endmodule

// ----- rtl/tap_hold_key_remapper_top.sv -----
// ----------------------------------------------------------------------------
// tap_hold_key_remapper_top
// dual-role key filter: tap gives the tap key, hold gives the hold modifier
// ----------------------------------------------------------------------------
// channel  modport  payload                                   role
// ev_in    sink     ev_type, ev_code, ev_value                input events
// ev_out   source   out_type, out_code, out_value, last       emitted events
// cfg      sink     index, data                               register writes
//
// an event is registered on accept, decoded from the input register and loaded into the
// output burst register once it is free; with ev_out ready one event per cycle flows through.
// an input causing three events holds the output until all three are taken, during
// which one more input waits in the input register, as there is a single burst slot.
// rst is synchronous: clears hold state, pending events and restores key codes.
// ev_out stalls back up through the input register to ev_in.ready.
// ----------------------------------------------------------------------------
`include "tap_hold_key_remapper_top_macros.svh"

module tap_hold_key_remapper_top (
  input  logic       clk,
  input  logic       rst,
  thkr_in_if.sink    ev_in,
  thkr_out_if.source ev_out,
  thkr_cfg_if.sink   cfg
);

  thkr_pkg::cfg_t   regs;
  thkr_pkg::item_t  inq;
  logic             inq_v;
  thkr_pkg::state_t st;
  thkr_pkg::dec_t   dec;
  logic             burst_free;
  logic             move;

  thkr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  assign move        = inq_v && burst_free;
  assign ev_in.ready = !inq_v || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_v <= 1'b0;
    end else if (ev_in.ready) begin
      inq_v <= ev_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_in.valid && ev_in.ready) begin
      inq.ev_type  <= ev_in.ev_type;
      inq.ev_code  <= ev_in.ev_code;
      inq.ev_value <= ev_in.ev_value;
    end
  end

  thkr_decode u_decode (
    .item (inq),
    .regs (regs),
    .st   (st),
    .dec  (dec)
  );

  // hold state advances when the decoded burst is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (move) begin
      st <= dec.st_next;
    end
  end

  thkr_burst u_burst (
    .clk    (clk),
    .rst    (rst),
    .load   (move),
    .burst  (dec.burst),
    .free   (burst_free),
    .ev_out (ev_out)
  );

  // hold can only be used while the key is held
  `THKR_ASSERT(a_used_needs_held, clk, rst, st.hold_used |-> st.held)
  // a waiting request is not dropped
  `THKR_ASSERT(a_inq_kept, clk, rst, (inq_v && !move) |=> inq_v)
  // a taken press sets held
  `THKR_ASSERT(a_held_follows, clk, rst, (move && dec.st_next.held) |=> st.held)

endmodule
